/* rtl/core/dvrt_pkg.sv */
// ----------------------------------------------------------------------------
// Distance-vector route table package
// Shared constants, operation codes and control structs for the route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

	// Default sizes for the top-level parameters.
	localparam int ENTRIES_DEF   = 64;
	localparam int PORTS_DEF     = 16;
	localparam int ADDR_BITS_DEF = 32;

	// Field widths of the input and result words.
	localparam int FUNC_W   = 2;
	localparam int DEST_IN_W = 32;
	localparam int METRIC_W = 16;
	localparam int HOPS_W   = 4;
	localparam int PORT_W   = 4;

	// Item kinds.
	localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INSTALL = 2'd2;

	// Metric is unsigned 8.8 fixed point.
	localparam logic [METRIC_W-1:0] METRIC_ONE = 16'h0100;
	localparam logic [METRIC_W-1:0] METRIC_MAX = 16'hFFFF;
	localparam logic [HOPS_W-1:0]   HOPS_ONE   = 4'd1;
	// An advertised hop count of this value would reach the hop limit of 16.
	localparam logic [HOPS_W-1:0]   HOPS_LAST  = 4'd15;

	// Configuration port.
	localparam int APB_DATA_W  = 32;
	localparam int PADDR_W     = 3;
	localparam int REG_IDX_LSB = 2;
	localparam int AP_W        = 5;
	localparam logic [AP_W-1:0] AP_RESET = 5'd16;
	localparam logic [PADDR_W-1:REG_IDX_LSB] REG_ACTIVE_PORTS = 1'b0;

	// Table write request from the decision logic.
	typedef struct packed {
		logic                en;
		logic                alloc;
		logic [PORT_W-1:0]   port;
		logic [METRIC_W-1:0] metric;
		logic [HOPS_W-1:0]   hops;
	} tbl_wr_t;

	// Lookup outcome from the table.
	typedef struct packed {
		logic                found;
		logic                full;
		logic [PORT_W-1:0]   port;
		logic [METRIC_W-1:0] metric;
	} tbl_rd_t;

endpackage

/* rtl/core/dvrt_if.sv */
// ----------------------------------------------------------------------------
// Distance-vector route table channels
// Valid/ready interfaces for the item word and the result word.
// ----------------------------------------------------------------------------
interface dvrt_item_if;
	logic                           valid;
	logic                           ready;
	logic [dvrt_pkg::FUNC_W-1:0]    func;
	logic [dvrt_pkg::DEST_IN_W-1:0] dest_addr;
	logic [dvrt_pkg::METRIC_W-1:0]  adv_metric;
	logic [dvrt_pkg::HOPS_W-1:0]    adv_hops;
	logic [dvrt_pkg::PORT_W-1:0]    in_port;

	modport source (output valid, func, dest_addr, adv_metric, adv_hops, in_port,
		input ready);
	modport sink (input valid, func, dest_addr, adv_metric, adv_hops, in_port,
		output ready);
endinterface

interface dvrt_result_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [dvrt_pkg::PORT_W-1:0] out_port;
	logic                        flood;
	logic [dvrt_pkg::PORT_W-1:0] excluded_port;
	logic                        changed;
	logic                        table_full;

	modport source (output valid, hit, out_port, flood, excluded_port, changed,
		table_full, input ready);
	modport sink (input valid, hit, out_port, flood, excluded_port, changed,
		table_full, output ready);
endinterface

/* rtl/core/dvrt_cfg.sv */
// ----------------------------------------------------------------------------
// Route table configuration registers
// APB write/read of the active port count.
// ----------------------------------------------------------------------------
module dvrt_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dvrt_pkg::PADDR_W-1:0]        paddr,
	input  logic [dvrt_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [dvrt_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [dvrt_pkg::AP_W-1:0]           active_ports
);

	logic [dvrt_pkg::AP_W-1:0] active_ports_q;
	logic                      sel_ap;

	assign sel_ap = (paddr[dvrt_pkg::PADDR_W-1:dvrt_pkg::REG_IDX_LSB] ==
		dvrt_pkg::REG_ACTIVE_PORTS);

	// The register is written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_ports_q <= dvrt_pkg::AP_RESET;
		end else if (psel && penable && pwrite && sel_ap) begin
			active_ports_q <= pwdata[dvrt_pkg::AP_W-1:0];
		end
	end

	// Reads return the register, other addresses read as zero.
	assign prdata       = sel_ap ? dvrt_pkg::APB_DATA_W'(active_ports_q) : '0;
	assign pready       = 1'b1;
	assign active_ports = active_ports_q;

endmodule

/* rtl/core/dvrt_cam.sv */
// ----------------------------------------------------------------------------
// Route table storage
// Entry registers with a parallel destination compare and a fill counter.
// ----------------------------------------------------------------------------
module dvrt_cam #(
	parameter int ENTRIES = dvrt_pkg::ENTRIES_DEF,
	parameter int DEST_W  = dvrt_pkg::DEST_IN_W,
	localparam int IDX_W  = $clog2(ENTRIES),
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DEST_W-1:0]    key,
	input  dvrt_pkg::tbl_wr_t    wr,
	input  logic [IDX_W-1:0]     wr_idx,
	output dvrt_pkg::tbl_rd_t    rd,
	output logic [IDX_W-1:0]     match_idx,
	output logic [IDX_W-1:0]     free_idx,
	output logic [CNT_W-1:0]     fill_cnt
);

	logic [ENTRIES-1:0]                  valid_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [DEST_W-1:0]                   dest_q   [ENTRIES];
	logic [dvrt_pkg::PORT_W-1:0]         port_q   [ENTRIES];
	logic [dvrt_pkg::METRIC_W-1:0]       metric_q [ENTRIES];
	logic [dvrt_pkg::HOPS_W-1:0]         hops_q   [ENTRIES];
	logic [ENTRIES-1:0]                  match;

	// Every entry compares its tag against the key at once.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (dest_q[i] == key);
		end
	end

	// At most one entry matches, so the fields are merged with an AND-OR.
	// Entries are never freed, so the table is full once the count reaches
	// the table size.
	always_comb begin
		rd.found  = |match;
		rd.full   = (cnt_q == CNT_W'(ENTRIES));
		rd.port   = '0;
		rd.metric = '0;
		match_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				rd.port   = rd.port | port_q[i];
				rd.metric = rd.metric | metric_q[i];
				match_idx = match_idx | IDX_W'(i);
			end
		end
	end

	// Entries are never freed, so the lowest free entry is the fill count.
	assign free_idx  = cnt_q[IDX_W-1:0];
	assign fill_cnt  = cnt_q;

	// Entry payload carries no reset.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			dest_q[wr_idx]   <= key;
			port_q[wr_idx]   <= wr.port;
			metric_q[wr_idx] <= wr.metric;
			hops_q[wr_idx]   <= wr.hops;
		end
	end

	// Valid bits and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (wr.en && wr.alloc) begin
			valid_q[wr_idx] <= 1'b1;
			cnt_q           <= cnt_q + 1'b1;
		end
	end

endmodule

/* rtl/core/distance_vector_route_table_core.sv */
// ----------------------------------------------------------------------------
// Distance-vector route table core
// An accepted word is held in the input register, takes the tag compare and any
// table write as it moves into the result register, and waits there until its
// result word is accepted; one word per cycle while the result channel is ready.
// Reset clears the valid bits, the fill count and the pipeline valids, and
// sets active_ports to 16; entry contents stay undefined until written.
// ----------------------------------------------------------------------------
module distance_vector_route_table_core #(
	parameter int ENTRIES   = dvrt_pkg::ENTRIES_DEF,
	parameter int PORTS     = dvrt_pkg::PORTS_DEF,
	parameter int ADDR_BITS = dvrt_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dvrt_pkg::PADDR_W-1:0]    paddr,
	input  logic [dvrt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dvrt_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	dvrt_item_if.sink                       item,
	dvrt_result_if.source                   result
);

	localparam int DEST_W = (ADDR_BITS < dvrt_pkg::DEST_IN_W) ? ADDR_BITS :
		dvrt_pkg::DEST_IN_W;
	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	logic [dvrt_pkg::AP_W-1:0] active_ports;

	// Input register.
	logic                            valid_s1;
	logic [dvrt_pkg::FUNC_W-1:0]     func_s1;
	logic [DEST_W-1:0]               dest_s1;
	logic [dvrt_pkg::METRIC_W-1:0]   metric_s1;
	logic [dvrt_pkg::HOPS_W-1:0]     hops_s1;
	logic [dvrt_pkg::PORT_W-1:0]     port_s1;
	logic                            adv_s1;

	// Result register.
	logic                            valid_s2;
	logic                            hit_s2;
	logic [dvrt_pkg::PORT_W-1:0]     out_port_s2;
	logic                            flood_s2;
	logic [dvrt_pkg::PORT_W-1:0]     excl_s2;
	logic                            changed_s2;
	logic                            full_s2;

	// Table interface and decision outputs.
	dvrt_pkg::tbl_wr_t               wr;
	dvrt_pkg::tbl_wr_t               wr_gated;
	dvrt_pkg::tbl_rd_t               rd;
	logic [IDX_W-1:0]                wr_idx;
	logic [IDX_W-1:0]                match_idx;
	logic [IDX_W-1:0]                free_idx;
	logic [CNT_W-1:0]                fill_cnt;
	logic                            hit_d;
	logic [dvrt_pkg::PORT_W-1:0]     out_port_d;
	logic                            flood_d;
	logic [dvrt_pkg::PORT_W-1:0]     excl_d;
	logic                            changed_d;
	logic                            full_d;
	logic [dvrt_pkg::METRIC_W:0]     metric_sum;
	logic [dvrt_pkg::METRIC_W-1:0]   new_metric;
	logic [dvrt_pkg::HOPS_W-1:0]     new_hops;
	logic                            port_ok;

	dvrt_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.active_ports (active_ports)
	);

	dvrt_cam #(
		.ENTRIES (ENTRIES),
		.DEST_W  (DEST_W)
	) u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (dest_s1),
		.wr        (wr_gated),
		.wr_idx    (wr_idx),
		.rd        (rd),
		.match_idx (match_idx),
		.free_idx  (free_idx),
		.fill_cnt  (fill_cnt)
	);

	// The input register moves on whenever the result register is free or
	// is being emptied in the same cycle.
	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1   <= item.func;
			dest_s1   <= item.dest_addr[DEST_W-1:0];
			metric_s1 <= item.adv_metric;
			hops_s1   <= item.adv_hops;
			port_s1   <= item.in_port;
		end
	end

	// Advertised metric plus 1.0, saturating; hop count plus one.
	assign metric_sum = {1'b0, metric_s1} + {1'b0, dvrt_pkg::METRIC_ONE};
	assign new_metric = metric_sum[dvrt_pkg::METRIC_W] ? dvrt_pkg::METRIC_MAX :
		metric_sum[dvrt_pkg::METRIC_W-1:0];
	assign new_hops   = hops_s1 + 1'b1;

	// A next hop is usable below both the active port count and PORTS.
	assign port_ok = rd.found && ({1'b0, rd.port} < active_ports) &&
		(32'(rd.port) < PORTS);

	// Per-kind decision on the looked-up entry.
	always_comb begin
		wr         = '0;
		wr_idx     = match_idx;
		hit_d      = 1'b0;
		out_port_d = '0;
		flood_d    = 1'b0;
		excl_d     = '0;
		changed_d  = 1'b0;
		full_d     = 1'b0;
		case (func_s1)
			dvrt_pkg::FUNC_UPDATE: begin
				wr.port   = port_s1;
				wr.metric = new_metric;
				wr.hops   = new_hops;
				if (hops_s1 != dvrt_pkg::HOPS_LAST) begin
					if (rd.found) begin
						if (new_metric < rd.metric) begin
							wr.en     = 1'b1;
							changed_d = 1'b1;
						end
					end else if (!rd.full) begin
						wr.en     = 1'b1;
						wr.alloc  = 1'b1;
						wr_idx    = free_idx;
						changed_d = 1'b1;
					end else begin
						full_d = 1'b1;
					end
				end
			end
			dvrt_pkg::FUNC_LOOKUP: begin
				if (port_ok) begin
					hit_d      = 1'b1;
					out_port_d = rd.port;
				end else begin
					flood_d = 1'b1;
					excl_d  = port_s1;
				end
			end
			dvrt_pkg::FUNC_INSTALL: begin
				wr.port   = port_s1;
				wr.metric = dvrt_pkg::METRIC_ONE;
				wr.hops   = dvrt_pkg::HOPS_ONE;
				if (rd.found) begin
					wr.en     = 1'b1;
					changed_d = 1'b1;
				end else if (!rd.full) begin
					wr.en     = 1'b1;
					wr.alloc  = 1'b1;
					wr_idx    = free_idx;
					changed_d = 1'b1;
				end else begin
					full_d = 1'b1;
				end
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	// The table is written only when the word moves into the result register.
	always_comb begin
		wr_gated    = wr;
		wr_gated.en = wr.en && adv_s1;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_s2      <= hit_d;
			out_port_s2 <= out_port_d;
			flood_s2    <= flood_d;
			excl_s2     <= excl_d;
			changed_s2  <= changed_d;
			full_s2     <= full_d;
		end
	end

	assign result.valid         = valid_s2;
	assign result.hit           = hit_s2;
	assign result.out_port      = out_port_s2;
	assign result.flood         = flood_s2;
	assign result.excluded_port = excl_s2;
	assign result.changed       = changed_s2;
	assign result.table_full    = full_s2;

	// The fill count never runs past the table size.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt <= CNT_W'(ENTRIES))
		else $error("route table fill count overflow");

	// An allocating write bumps the fill count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_gated.en && wr_gated.alloc |=> fill_cnt == $past(fill_cnt) + 1'b1)
		else $error("route table allocation did not advance fill count");

	// A dropped write is reported only when the table is full, and it stays full.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && full_d |=> fill_cnt == CNT_W'(ENTRIES))
		else $error("table_full reported with free entries");

	// An accepted word is held in the input register in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> valid_s1)
		else $error("accepted word lost before the table pass");

endmodule
